// ===== hw/rtl/ksht_pkg.sv =====
package ksht_pkg;

    localparam int HELD_SLOTS_DEF  = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int HOLD_TICKS_RST  = 100;

    localparam logic [1:0] ACT_KEY  = 2'd0;
    localparam logic [1:0] ACT_ALT  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] KIND_MAKE  = 2'd0;
    localparam logic [1:0] KIND_BREAK = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam logic [7:0] LETTER_SC [26] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C
    };

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] key_code;
    } t_request;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] scancode_out;
        logic [7:0] ascii_out;
        logic       extended_out;
        logic       last_out;
    } t_result;

    // wave that walks the cell row, one cell per cycle
    typedef struct packed {
        logic       active;
        logic       claim;   // 1 free-slot claim, 0 expired-minimum search
        logic       found;
        logic [7:0] sc;
        logic       ext;
    } t_wave;

    // control broadcast to every cell
    typedef struct packed {
        logic        age_en;
        logic        cmp_en;
        logic [7:0]  cmp_sc;
        logic        rel_en;
        logic [7:0]  rel_sc;
        logic [7:0]  cl_sc;
        logic        cl_ext;
        logic [15:0] hold_ticks;
    } t_bcast;

    typedef struct packed {
        logic [7:0] sc;
        logic [7:0] ascii;
        logic       ext;
    } t_xlat;

    function automatic t_xlat xlat(input logic [1:0] action, input logic [8:0] key);
        t_xlat      x;
        logic [7:0] k8;
        logic [7:0] d;
        k8 = key[7:0];
        x  = '0;
        d  = '0;
        if (action == ACT_KEY && key[8]) begin
            x.ext = 1'b1;
            if (key == 9'h185) begin
                x.sc = 8'h57;
            end else if (key == 9'h186) begin
                x.sc = 8'h58;
            end else if (k8 <= 8'h53) begin
                case (k8) inside
                    [8'h3B:8'h44], 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4D,
                    8'h4F, 8'h50, 8'h51, 8'h52, 8'h53: x.sc = k8;
                    default: x.sc = 8'h00;
                endcase
            end
        end else if (action == ACT_KEY) begin
            x.ascii = k8;
            case (k8) inside
                8'h1B:        x.sc = 8'h01;
                8'h31, 8'h21: x.sc = 8'h02;
                8'h32, 8'h40: x.sc = 8'h03;
                8'h33, 8'h23: x.sc = 8'h04;
                8'h34, 8'h24: x.sc = 8'h05;
                8'h35, 8'h25: x.sc = 8'h06;
                8'h36, 8'h5E: x.sc = 8'h07;
                8'h37, 8'h26: x.sc = 8'h08;
                8'h38, 8'h2A: x.sc = 8'h09;
                8'h39, 8'h28: x.sc = 8'h0A;
                8'h30, 8'h29: x.sc = 8'h0B;
                8'h2D, 8'h5F: x.sc = 8'h0C;
                8'h3D, 8'h2B: x.sc = 8'h0D;
                8'h08, 8'h7F: begin
                    x.sc    = 8'h0E;
                    x.ascii = 8'h08;
                end
                8'h09:        x.sc = 8'h0F;
                8'h5B, 8'h7B: x.sc = 8'h1A;
                8'h5D, 8'h7D: x.sc = 8'h1B;
                8'h0D, 8'h0A: begin
                    x.sc    = 8'h1C;
                    x.ascii = 8'h0D;
                end
                8'h3B, 8'h3A: x.sc = 8'h27;
                8'h27, 8'h22: x.sc = 8'h28;
                8'h60, 8'h7E: x.sc = 8'h29;
                8'h5C, 8'h7C: x.sc = 8'h2B;
                8'h2C, 8'h3C: x.sc = 8'h33;
                8'h2E, 8'h3E: x.sc = 8'h34;
                8'h2F, 8'h3F: x.sc = 8'h35;
                8'h20:        x.sc = 8'h39;
                [8'h61:8'h7A]: begin
                    d    = k8 - 8'h61;
                    x.sc = LETTER_SC[d[4:0]];
                end
                [8'h41:8'h5A]: begin
                    d    = k8 - 8'h41;
                    x.sc = LETTER_SC[d[4:0]];
                end
                [8'h01:8'h1A]: begin
                    // control letters
                    d    = k8 - 8'h01;
                    x.sc = LETTER_SC[d[4:0]];
                end
                default: begin
                    x.sc    = 8'h00;
                    x.ascii = 8'h00;
                end
            endcase
        end else if (action == ACT_ALT && !key[8]) begin
            case (k8) inside
                [8'h61:8'h7A]: begin
                    d    = k8 - 8'h61;
                    x.sc = LETTER_SC[d[4:0]];
                end
                [8'h41:8'h5A]: begin
                    d    = k8 - 8'h41;
                    x.sc = LETTER_SC[d[4:0]];
                end
                [8'h31:8'h39]: x.sc = 8'h78 + (k8 - 8'h31);
                8'h30:         x.sc = 8'h81;
                8'h2D:         x.sc = 8'h82;
                8'h3D:         x.sc = 8'h83;
                default:       x.sc = 8'h00;
            endcase
        end
        return x;
    endfunction

endpackage

// ===== hw/rtl/ksht_cell.sv =====
module ksht_cell
    import ksht_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  t_wave  i_wave,
    output t_wave  o_wave,
    output logic   o_hit
);

    logic        r_valid;
    logic [7:0]  r_sc;
    logic        r_ext;
    logic [15:0] r_age;
    t_wave       r_wave;
    t_wave       n_wave;
    logic        expired;
    logic        claim_me;
    logic        release_me;

    assign expired    = r_age >= i_bc.hold_ticks;
    assign o_hit      = i_bc.cmp_en && r_valid && (r_sc == i_bc.cmp_sc);
    assign claim_me   = i_wave.active && i_wave.claim && !i_wave.found && !r_valid;
    assign release_me = i_bc.rel_en && r_valid && (r_sc == i_bc.rel_sc);
    assign o_wave     = r_wave;

    always_comb begin
        n_wave = i_wave;
        if (claim_me) begin
            n_wave.found = 1'b1;
        end else if (i_wave.active && !i_wave.claim && r_valid && expired &&
                     (!i_wave.found || r_sc < i_wave.sc)) begin
            n_wave.found = 1'b1;
            n_wave.sc    = r_sc;
            n_wave.ext   = r_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= '0;
        end else begin
            r_wave <= n_wave;
            if (claim_me) begin
                r_valid <= 1'b1;
            end else if (release_me) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim_me) begin
            r_sc  <= i_bc.cl_sc;
            r_ext <= i_bc.cl_ext;
            r_age <= '0;
        end else if (o_hit) begin
            r_age <= '0;
        end else if (i_bc.age_en && r_valid && r_age != 16'hFFFF) begin
            r_age <= r_age + 16'd1;
        end
    end

endmodule

// ===== hw/rtl/ksht_ctrl.sv =====
module ksht_ctrl
    import ksht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_any_hit,
    input  t_wave       i_wave_out,
    output t_wave       o_launch,
    output t_bcast      o_bc,
    output logic        o_strobe,
    output t_result     o_result
);

    localparam int CNT_W = $clog2(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MATCH, ST_CLAIM_WAIT, ST_AGE, ST_SRCH_WAIT, ST_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [7:0]         r_sc, n_sc;
    logic [7:0]         r_ascii, n_ascii;
    logic               r_ext, n_ext;
    logic [15:0]        r_hold;
    t_wave              r_launch, n_launch;
    logic               r_pend, n_pend;
    logic [7:0]         r_psc, n_psc;
    logic               r_pext, n_pext;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_strobe, n_strobe;
    t_result            r_result, n_result;
    t_xlat              x;
    t_wave              search_wave;

    assign busy     = r_state != ST_IDLE;
    assign o_launch = r_launch;
    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign x        = xlat(i_req.action, i_req.key_code);

    always_comb begin
        search_wave        = '0;
        search_wave.active = 1'b1;
    end

    always_comb begin
        o_bc            = '0;
        o_bc.age_en     = r_state == ST_AGE;
        o_bc.cmp_en     = r_state == ST_MATCH;
        o_bc.cmp_sc     = r_sc;
        o_bc.rel_en     = (r_state == ST_SRCH_WAIT) && i_wave_out.active && i_wave_out.found;
        o_bc.rel_sc     = i_wave_out.sc;
        o_bc.cl_sc      = r_sc;
        o_bc.cl_ext     = r_ext;
        o_bc.hold_ticks = r_hold;
    end

    always_comb begin
        n_state  = r_state;
        n_sc     = r_sc;
        n_ascii  = r_ascii;
        n_ext    = r_ext;
        n_launch = '0;
        n_pend   = r_pend;
        n_psc    = r_psc;
        n_pext   = r_pext;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_result = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.action == ACT_TICK) begin
                        n_state = ST_AGE;
                    end else if (x.sc != 8'h00) begin
                        n_state = ST_MATCH;
                        n_sc    = x.sc;
                        n_ascii = x.ascii;
                        n_ext   = x.ext;
                    end
                end
            end
            ST_MATCH: begin
                // a held key only has its age cleared
                if (i_any_hit) begin
                    n_state = ST_IDLE;
                end else begin
                    n_launch       = '0;
                    n_launch.active = 1'b1;
                    n_launch.claim  = 1'b1;
                    n_state         = ST_CLAIM_WAIT;
                end
            end
            ST_CLAIM_WAIT: begin
                if (i_wave_out.active) begin
                    n_strobe              = 1'b1;
                    n_result.event_kind   = i_wave_out.found ? KIND_MAKE : KIND_DROP;
                    n_result.scancode_out = r_sc;
                    n_result.ascii_out    = r_ascii;
                    n_result.extended_out = r_ext;
                    n_result.last_out     = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            ST_AGE: begin
                n_pend   = 1'b0;
                n_cnt    = '0;
                n_launch = search_wave;
                n_state  = ST_SRCH_WAIT;
            end
            ST_SRCH_WAIT: begin
                if (i_wave_out.active) begin
                    // previous break goes out once we know whether another follows
                    if (r_pend) begin
                        n_strobe              = 1'b1;
                        n_result.event_kind   = KIND_BREAK;
                        n_result.scancode_out = r_psc;
                        n_result.ascii_out    = 8'h00;
                        n_result.extended_out = r_pext;
                        n_result.last_out     = !i_wave_out.found;
                    end
                    if (i_wave_out.found) begin
                        n_pend = 1'b1;
                        n_psc  = i_wave_out.sc;
                        n_pext = i_wave_out.ext;
                        n_cnt  = r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_launch = search_wave;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                n_strobe              = 1'b1;
                n_result.event_kind   = KIND_BREAK;
                n_result.scancode_out = r_psc;
                n_result.ascii_out    = 8'h00;
                n_result.extended_out = r_pext;
                n_result.last_out     = 1'b1;
                n_state               = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= '0;
            r_pend   <= 1'b0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_hold   <= 16'(HOLD_TICKS_RST);
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            r_sc     <= n_sc;
            r_ascii  <= n_ascii;
            r_ext    <= n_ext;
            r_psc    <= n_psc;
            r_pext   <= n_pext;
            r_result <= n_result;
        end
    end

endmodule

// ===== hw/rtl/keystroke_scancode_hold_table_unit.sv =====
// Key event to set-1 scancode translator with a table of held keys.
// A request is taken at a rising edge with start high and busy low; i_req
// carries the action (key, Alt plus character, one millisecond tick) and
// the key code. hold_ticks is written through i_cfg_we / i_cfg_wdata, by
// the user only while the block is idle; the block does not enforce it.
// Results appear on o_result for one cycle each, marked by o_strobe; the
// final result of a request has last_out set. The receiver cannot stall.
// Held keys sit in a row of HELD_SLOTS cells; a wave register steps one cell
// per cycle, and a row walk passes the launch register and every cell.
// Key or Alt request: a compare step, then for a new key a claim walk; the
// make or drop result is registered from the walk's end and busy drops in
// the same cycle that it appears; held keys finish after the compare with
// no result, and unmapped keys give no result and never raise busy.
// Tick request: an aging step, then one search walk per released key plus
// a final walk that finds none; at the limit of 16 breaks the final walk
// gives way to a flush step.
// Breaks come out in ascending scancode order.
// Reset clears the held table, the control state and sets hold_ticks to 100.
module keystroke_scancode_hold_table_unit
    import ksht_pkg::*;
#(
    parameter int HELD_SLOTS = HELD_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output t_result     o_result
);

    t_wave                  wave [HELD_SLOTS+1];
    logic [HELD_SLOTS-1:0]  hits;
    t_bcast                 bc;

    ksht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_any_hit   (|hits),
        .i_wave_out  (wave[HELD_SLOTS]),
        .o_launch    (wave[0]),
        .o_bc        (bc),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    for (genvar g = 0; g < HELD_SLOTS; g++) begin : g_cell
        ksht_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (bc),
            .i_wave  (wave[g]),
            .o_wave  (wave[g+1]),
            .o_hit   (hits[g])
        );
    end

endmodule

// ===== hw/rtl/ksht_chk.sv =====
module ksht_chk
    import ksht_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // a request that is not finished keeps the block busy
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_out |-> busy)
        else $error("non-final result while idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_out |-> !busy)
        else $error("final result while still busy");

    // make and drop are always the only result of their request
    a_press_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.event_kind == KIND_MAKE || o_result.event_kind == KIND_DROP)
        |-> o_result.last_out)
        else $error("press result not marked last");

    a_break_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.event_kind != KIND_MAKE && o_result.event_kind != KIND_DROP
        |-> o_result.event_kind == KIND_BREAK && o_result.ascii_out == 8'h00)
        else $error("bad break result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("activity right after reset");

endmodule

bind keystroke_scancode_hold_table_unit ksht_chk u_ksht_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
